[hdl/idq_pkg.sv]
// idq_pkg: shared types, widths and codes for the stock-record deque.
// No dependencies; every other file of the block uses it.
package idq_pkg;

  localparam int unsigned DEPTH_DEF = 16;

  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CODE_W  = 40;
  localparam int unsigned AMT_W   = 16;
  localparam int unsigned PRICE_W = 24;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned COST_W  = 40;

  localparam logic [CMD_W-1:0] CMD_PUSH_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_HEAD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_TAIL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SELL      = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_BADQTY   = 3'd4;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [AMT_W-1:0]   amount;
    logic [PRICE_W-1:0] price;
  } rec_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [CODE_W-1:0]  item_code;
    logic [AMT_W-1:0]   amount;
    logic [PRICE_W-1:0] unit_price;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [CODE_W-1:0]  out_code;
    logic [AMT_W-1:0]   out_amount;
    logic [PRICE_W-1:0] out_price;
    logic [COST_W-1:0]  total_cost;
  } res_t;

endpackage

[hdl/idq_if.sv]
// idq_if: command and response channel interfaces (valid/ready plus payload).
// Depends on idq_pkg for field widths.
interface idq_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [idq_pkg::CMD_W-1:0]   command;
  logic [idq_pkg::CODE_W-1:0]  item_code;
  logic [idq_pkg::AMT_W-1:0]   amount;
  logic [idq_pkg::PRICE_W-1:0] unit_price;

  modport source (output valid, command, item_code, amount, unit_price, input ready);
  modport sink   (input valid, command, item_code, amount, unit_price, output ready);
endinterface

interface idq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [idq_pkg::STAT_W-1:0]  status;
  logic [idq_pkg::CODE_W-1:0]  out_code;
  logic [idq_pkg::AMT_W-1:0]   out_amount;
  logic [idq_pkg::PRICE_W-1:0] out_price;
  logic [idq_pkg::COST_W-1:0]  total_cost;

  modport source (output valid, status, out_code, out_amount, out_price, total_cost,
                  input ready);
  modport sink   (input valid, status, out_code, out_amount, out_price, total_cost,
                  output ready);
endinterface

[hdl/idq_store.sv]
// idq_store: record memory, one write port and one registered read port.
// Depends on idq_pkg for the record type.
module idq_store #(
  parameter int unsigned DEPTH = idq_pkg::DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output idq_pkg::rec_t   rd_data_o,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  idq_pkg::rec_t   wr_data_i
);

  idq_pkg::rec_t mem_q [DEPTH];
  idq_pkg::rec_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/idq_ctrl.sv]
// idq_ctrl: command sequencer; ring pointers, memory read/modify/write, sell scan.
// Depends on idq_pkg; drives idq_store.
module idq_ctrl #(
  parameter int unsigned DEPTH = idq_pkg::DEPTH_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  idq_pkg::cmd_t cmd_i,
  output idq_pkg::res_t res_o,
  output logic          res_load_o,
  input  logic          res_free_i,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  idq_pkg::rec_t rd_data_i,
  output logic          wr_en_o,
  output logic [AW-1:0] wr_addr_o,
  output idq_pkg::rec_t wr_data_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_POP  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]    state_q, state_d;
  idq_pkg::cmd_t cmd_q, cmd_d;
  idq_pkg::res_t res_q, res_d;
  logic [AW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] k_q, k_d;
  logic          cmp_v_q, cmp_v_d;
  logic [AW-1:0] cmp_slot_q, cmp_slot_d;

  logic [AW-1:0] front_dec, front_inc, slot_tail, slot_last, slot_k;
  logic          full, empty, hit;
  logic [idq_pkg::AMT_W-1:0]  left_amt;
  logic [idq_pkg::COST_W-1:0] cost;

  function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = (AW+1)'(base) + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign front_dec = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = ring_slot(front_q, CW'(1));
  assign slot_tail = ring_slot(front_q, count_q);
  assign slot_last = ring_slot(front_q, count_q - 1'b1);
  assign slot_k    = ring_slot(front_q, k_q);
  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign hit       = cmp_v_q && (rd_data_i.code == cmd_q.item_code);
  assign left_amt  = rd_data_i.amount - cmd_q.amount;
  assign cost      = idq_pkg::COST_W'(rd_data_i.price) * idq_pkg::COST_W'(cmd_q.amount);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    res_d       = res_q;
    front_d     = front_q;
    count_d     = count_q;
    k_d         = k_q;
    cmp_v_d     = cmp_v_q;
    cmp_slot_d  = cmp_slot_q;
    cmd_ready_o = (state_q == S_IDLE);
    res_load_o  = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = front_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = slot_tail;
    wr_data_o   = '{code: cmd_q.item_code, amount: cmd_q.amount, price: cmd_q.unit_price};

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d   = cmd_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_d   = '0;
        state_d = S_RESP;
        case (cmd_q.command)
          idq_pkg::CMD_PUSH_HEAD, idq_pkg::CMD_PUSH_TAIL: begin
            if (full) begin
              res_d.status = idq_pkg::ST_FULL;
            end else begin
              wr_en_o = 1'b1;
              count_d = count_q + 1'b1;
              if (cmd_q.command == idq_pkg::CMD_PUSH_HEAD) begin
                wr_addr_o = front_dec;
                front_d   = front_dec;
              end
            end
          end
          idq_pkg::CMD_POP_HEAD, idq_pkg::CMD_POP_TAIL: begin
            if (empty) begin
              res_d.status = idq_pkg::ST_EMPTY;
            end else begin
              rd_en_o   = 1'b1;
              rd_addr_o = (cmd_q.command == idq_pkg::CMD_POP_HEAD) ? front_q : slot_last;
              state_d   = S_POP;
            end
          end
          idq_pkg::CMD_SELL: begin
            if (empty) begin
              res_d.status = idq_pkg::ST_NOTFOUND;
            end else begin
              k_d     = '0;
              cmp_v_d = 1'b0;
              state_d = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        res_d.out_code   = rd_data_i.code;
        res_d.out_amount = rd_data_i.amount;
        res_d.out_price  = rd_data_i.price;
        count_d          = count_q - 1'b1;
        if (cmd_q.command == idq_pkg::CMD_POP_HEAD) begin
          front_d = front_inc;
        end
        state_d = S_RESP;
      end
      S_SCAN: begin
        if (hit) begin
          state_d = S_RESP;
          if (cmd_q.amount == '0 || cmd_q.amount > rd_data_i.amount) begin
            res_d.status = idq_pkg::ST_BADQTY;
          end else begin
            wr_en_o          = 1'b1;
            wr_addr_o        = cmp_slot_q;
            wr_data_o        = '{code: rd_data_i.code, amount: left_amt,
                                 price: rd_data_i.price};
            res_d.out_code   = rd_data_i.code;
            res_d.out_amount = left_amt;
            res_d.out_price  = rd_data_i.price;
            res_d.total_cost = cost;
          end
        end else if (k_q < count_q) begin
          rd_en_o    = 1'b1;
          rd_addr_o  = slot_k;
          cmp_slot_d = slot_k;
          cmp_v_d    = 1'b1;
          k_d        = k_q + 1'b1;
        end else begin
          res_d.status = idq_pkg::ST_NOTFOUND;
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        if (res_free_i) begin
          res_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      front_q <= '0;
      count_q <= '0;
      k_q     <= '0;
      cmp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      count_q <= count_d;
      k_q     <= k_d;
      cmp_v_q <= cmp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    res_q      <= res_d;
    cmp_slot_q <= cmp_slot_d;
  end

  assign res_o = res_q;

endmodule

[hdl/inventory_deque_with_keyed_sell.sv]
// inventory_deque_with_keyed_sell: top level; sequencer, record memory, response register.
// Depends on idq_pkg, idq_if, idq_store and idq_ctrl.
//
//   channel  dir  handshake        word
//   cmd_i    in   valid / ready    command, item_code, amount, unit_price
//   rsp_o    out  valid / ready    status, out_code, out_amount, out_price, total_cost
//
// One command at a time: a push passes IDLE, EXEC and RESP, a pop adds POP after EXEC,
// and a sell adds the sell scan over the stored records, reading one record per cycle from
// the single memory read port. The response word shows on rsp_o as the sequencer is back in idle.
// Reset clears the head pointer and record count; the memory is not cleared.
// A response waiting on rsp_o does not block the next command; the sequencer stalls
// only when a new response is ready while the previous one is still held.
module inventory_deque_with_keyed_sell #(
  parameter int unsigned DEPTH = idq_pkg::DEPTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  idq_cmd_if.sink    cmd_i,
  idq_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  idq_pkg::cmd_t cmd_word;
  idq_pkg::res_t res_word;
  idq_pkg::res_t out_q;
  logic          out_valid_q;
  logic          res_load, res_free;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  idq_pkg::rec_t rd_data, wr_data;

  assign cmd_word = '{command: cmd_i.command, item_code: cmd_i.item_code,
                      amount: cmd_i.amount, unit_price: cmd_i.unit_price};
  assign res_free = !out_valid_q || rsp_o.ready;

  idq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .cmd_i       (cmd_word),
    .res_o       (res_word),
    .res_load_o  (res_load),
    .res_free_i  (res_free),
    .rd_en_o     (rd_en),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  idq_store #(.DEPTH(DEPTH)) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res_word;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_q.status;
  assign rsp_o.out_code   = out_q.out_code;
  assign rsp_o.out_amount = out_q.out_amount;
  assign rsp_o.out_price  = out_q.out_price;
  assign rsp_o.total_cost = out_q.total_cost;

endmodule

[hdl/idq_checker.sv]
// idq_checker: port-level assertions for the stock-record deque, bound to the top.
// Depends on idq_pkg and inventory_deque_with_keyed_sell.
module idq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cmd_valid_i,
  input logic                        cmd_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic [idq_pkg::STAT_W-1:0]  status_i,
  input logic [idq_pkg::CODE_W-1:0]  out_code_i,
  input logic [idq_pkg::AMT_W-1:0]   out_amount_i,
  input logic [idq_pkg::PRICE_W-1:0] out_price_i,
  input logic [idq_pkg::COST_W-1:0]  total_cost_i
);

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> status_i <= idq_pkg::ST_BADQTY)
    else $error("response status out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != idq_pkg::ST_OK |->
      out_code_i == '0 && out_amount_i == '0 && out_price_i == '0 && total_cost_i == '0)
    else $error("failed command carries nonzero fields");

  a_cost_sell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && total_cost_i != '0 |-> status_i == idq_pkg::ST_OK && out_price_i != '0)
    else $error("cost without a good sell");

  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command accepted while one is in flight");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) && $stable(total_cost_i))
    else $error("stalled response changed");

endmodule

bind inventory_deque_with_keyed_sell idq_checker u_idq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .out_code_i   (rsp_o.out_code),
  .out_amount_i (rsp_o.out_amount),
  .out_price_i  (rsp_o.out_price),
  .total_cost_i (rsp_o.total_cost)
);
